// ----- rtl/pixel_shift_orbit_generator_unit_assert.svh -----
// Assertion macros for the pixel shift orbit generator.
// Used by modules that have clk and arst_n in scope.
`ifndef PIXEL_SHIFT_ORBIT_GENERATOR_UNIT_ASSERT_SVH
`define PIXEL_SHIFT_ORBIT_GENERATOR_UNIT_ASSERT_SVH

// implication in the same cycle
`define PSOG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define PSOG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/psog_pkg.sv -----
// Package for the pixel shift orbit generator: widths, constants, register map,
// configuration and controller/datapath structs. No dependencies.
`default_nettype none

package psog_pkg;

	localparam int PHASE_FRAC_BITS_DEF = 24;

	localparam int ELAPSED_W     = 20;
	localparam int ELAPSED_CAP_W = 17;
	localparam int ROOM_W        = 16;
	localparam int SHIFT_W       = 13;
	localparam int RANGE_W       = 12;
	localparam int SPEED_W       = 16;
	localparam int NUM_W         = ELAPSED_CAP_W + SPEED_W;
	localparam int DEN_W         = 32;
	localparam int STEP_INT_BITS = 13;
	localparam int GOLD_W        = 32;

	localparam logic [ELAPSED_CAP_W-1:0] ELAPSED_CAP = 17'd100000;
	localparam logic [DEN_W-RANGE_W-1:0] US_PER_S    = 20'd1000000;
	localparam logic [GOLD_W-1:0]        GOLD_Q32    = 32'h9E3779B9;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_RANGE  = 2'd0;
	localparam logic [1:0] REG_SPEED  = 2'd1;
	localparam logic [1:0] REG_FLIP_X = 2'd2;
	localparam logic [1:0] REG_FLIP_Y = 2'd3;

	localparam logic [RANGE_W-1:0] RANGE_RST = 12'd128;
	localparam logic [SPEED_W-1:0] SPEED_RST = 16'd16;

	typedef struct packed {
		logic [RANGE_W-1:0] range_q4;
		logic [SPEED_W-1:0] speed_q4;
		logic               flip_x;
		logic               flip_y;
	} cfg_t;

	typedef struct packed {
		logic ready;
		logic load;
		logic div_step;
		logic phase_upd;
		logic wave_ld;
		logic res_ld;
	} cmd_t;

	typedef struct packed {
		logic tick_valid;
		logic move;
		logic out_valid;
		logic out_ready;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/psog_tick_if.sv -----
// Input channel: one frame tick item (elapsed time and free room).
// Depends on psog_pkg.
`default_nettype none

interface psog_tick_if import psog_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [ELAPSED_W-1:0]        elapsed_us;
	logic signed [ROOM_W-1:0]    room_x_q4;
	logic signed [ROOM_W-1:0]    room_y_q4;

	modport source (output valid, output elapsed_us, output room_x_q4, output room_y_q4,
		input ready);
	modport sink (input valid, input elapsed_us, input room_x_q4, input room_y_q4,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/psog_shift_if.sv -----
// Output channel: one displacement item per tick.
// Depends on psog_pkg.
`default_nettype none

interface psog_shift_if import psog_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SHIFT_W-1:0] shift_x_q4;
	logic signed [SHIFT_W-1:0] shift_y_q4;

	modport source (output valid, output shift_x_q4, output shift_y_q4, input ready);
	modport sink (input valid, input shift_x_q4, input shift_y_q4, output ready);
endinterface

`default_nettype wire

// ----- rtl/psog_regs.sv -----
// APB-style configuration registers of the orbit generator.
// Depends on psog_pkg.
`default_nettype none

module psog_regs import psog_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_q4 <= RANGE_RST;
			cfg_q.speed_q4 <= SPEED_RST;
			cfg_q.flip_x   <= 1'b0;
			cfg_q.flip_y   <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_RANGE:  cfg_q.range_q4 <= pwdata[RANGE_W-1:0];
				REG_SPEED:  cfg_q.speed_q4 <= pwdata[SPEED_W-1:0];
				REG_FLIP_X: cfg_q.flip_x   <= pwdata[0];
				REG_FLIP_Y: cfg_q.flip_y   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RANGE:  prdata = {{(APB_DATA_W-RANGE_W){1'b0}}, cfg_q.range_q4};
			REG_SPEED:  prdata = {{(APB_DATA_W-SPEED_W){1'b0}}, cfg_q.speed_q4};
			REG_FLIP_X: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.flip_x};
			REG_FLIP_Y: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.flip_y};
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/psog_dp.sv -----
// Datapath: bit-serial step divider with golden-ratio accumulator, phase
// registers, triangle wave, scaling and output register. Depends on psog_pkg.
`default_nettype none

module psog_dp import psog_pkg::*; #(
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	psog_tick_if.sink        tick,
	psog_shift_if.source     result
);

	localparam int F  = PHASE_FRAC_BITS;
	localparam int QW = F + STEP_INT_BITS;
	localparam int PW = F + 1;
	localparam int AW = F + 1 + GOLD_W;
	localparam logic [PW-1:0] ONE = {1'b1, {F{1'b0}}};

	function automatic logic [PW-1:0] tri_wave(input logic [PW-1:0] ph);
		logic [PW-1:0] span_v;
		span_v = (ph >= ONE) ? (ph - ONE) : (ONE - ph);
		return (span_v >= ONE) ? '0 : (ONE - span_v);
	endfunction

	function automatic logic [RANGE_W-1:0] clamp_lim(input logic [RANGE_W-1:0] rng,
		input logic [ROOM_W-1:0] room);
		logic [ROOM_W-2:0] rc;
		rc = room[ROOM_W-1] ? '0 : room[ROOM_W-2:0];
		return ({{(ROOM_W-1-RANGE_W){1'b0}}, rng} < rc) ? rng : rc[RANGE_W-1:0];
	endfunction

	logic [ELAPSED_CAP_W-1:0] e_cap;
	logic [NUM_W-1:0]         num;
	logic [DEN_W-1:0]         den;

	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [QW-1:0]      divb_q;
	logic [PW-1:0]      quo_q;
	logic [AW-1:0]      acc_q;
	logic [RANGE_W-1:0] lim_x_q, lim_y_q;
	logic [PW-1:0]      ph_h_q, ph_v_q;
	logic [PW-1:0]      wave_x_q, wave_y_q;
	logic               out_valid_q;
	logic [SHIFT_W-1:0] shift_x_q, shift_y_q;

	logic [DEN_W:0]            r2, diff;
	logic                      ge;
	logic [PW+RANGE_W-1:0]     prod_x, prod_y;
	logic [SHIFT_W-1:0]        mag_x, mag_y;

	assign e_cap = (tick.elapsed_us > {{(ELAPSED_W-ELAPSED_CAP_W){1'b0}}, ELAPSED_CAP}) ?
		ELAPSED_CAP : tick.elapsed_us[ELAPSED_CAP_W-1:0];
	assign num = NUM_W'(e_cap) * NUM_W'(cfg.speed_q4);
	assign den = DEN_W'(cfg.range_q4) * DEN_W'(US_PER_S);

	assign r2   = {rem_q, divb_q[QW-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	assign prod_x = {{RANGE_W{1'b0}}, wave_x_q} * {{PW{1'b0}}, lim_x_q};
	assign prod_y = {{RANGE_W{1'b0}}, wave_y_q} * {{PW{1'b0}}, lim_y_q};
	assign mag_x  = {1'b0, prod_x[F+RANGE_W-1:F]};
	assign mag_y  = {1'b0, prod_y[F+RANGE_W-1:F]};

	assign tick.ready = cmd.ready;
	assign sts.tick_valid = tick.valid;
	assign sts.move       = (cfg.range_q4 != '0) && (tick.elapsed_us != '0);
	assign sts.out_valid  = out_valid_q;
	assign sts.out_ready  = result.ready;

	assign result.valid      = out_valid_q;
	assign result.shift_x_q4 = shift_x_q;
	assign result.shift_y_q4 = shift_y_q;

	// divider and scaling payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// quotient is below 2^13, so the top dividend bits already sit below den
			rem_q   <= {{(DEN_W-NUM_W+STEP_INT_BITS){1'b0}}, num[NUM_W-1:STEP_INT_BITS]};
			divb_q  <= {num[STEP_INT_BITS-1:0], {F{1'b0}}};
			den_q   <= den;
			quo_q   <= '0;
			acc_q   <= '0;
			lim_x_q <= clamp_lim(cfg.range_q4, tick.room_x_q4);
			lim_y_q <= clamp_lim(cfg.range_q4, tick.room_y_q4);
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			divb_q <= {divb_q[QW-2:0], 1'b0};
			quo_q  <= {quo_q[PW-2:0], ge};
			// step * G, MSB first, kept modulo 2^AW
			acc_q  <= {acc_q[AW-2:0], 1'b0} + (ge ? AW'(GOLD_Q32) : '0);
		end
		if (cmd.wave_ld) begin
			wave_x_q <= tri_wave(ph_h_q);
			wave_y_q <= tri_wave(ph_v_q);
		end
		if (cmd.res_ld) begin
			shift_x_q <= cfg.flip_x ? -mag_x : mag_x;
			shift_y_q <= cfg.flip_y ? -mag_y : mag_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_h_q      <= '0;
			ph_v_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.phase_upd) begin
				ph_h_q <= ph_h_q + quo_q;
				ph_v_q <= ph_v_q + acc_q[AW-1:GOLD_W];
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/psog_ctrl.sv -----
// Controller: sequences load, serial division, phase update, wave and result.
// Depends on psog_pkg and the assertion macro header.
`default_nettype none
`include "pixel_shift_orbit_generator_unit_assert.svh"

module psog_ctrl import psog_pkg::*; #(
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam int QW    = PHASE_FRAC_BITS + STEP_INT_BITS;
	localparam int CNT_W = $clog2(QW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_UPD,
		S_WAVE,
		S_MUL
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_busy;

	assign out_busy = sts.out_valid && !sts.out_ready;

	always_comb begin
		cmd.ready     = (state_q == S_IDLE);
		cmd.load      = (state_q == S_IDLE) && sts.tick_valid;
		cmd.div_step  = (state_q == S_DIV);
		cmd.phase_upd = (state_q == S_UPD);
		cmd.wave_ld   = (state_q == S_WAVE);
		cmd.res_ld    = (state_q == S_MUL) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (sts.tick_valid) begin
						state_q <= sts.move ? S_DIV : S_WAVE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= S_WAVE;
				S_WAVE: state_q <= S_MUL;
				S_MUL: begin
					if (!out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PSOG_ASSERT_SAME(a_div_cnt_bound, state_q == S_DIV, cnt_q <= LAST,
		"divider count past last quotient bit")
	`PSOG_ASSERT_NEXT(a_div_to_upd, (state_q == S_DIV) && (cnt_q == LAST), state_q == S_UPD,
		"divider did not hand over to phase update")
	`PSOG_ASSERT_NEXT(a_res_fills_out, cmd.res_ld, sts.out_valid,
		"result load left output register empty")
	`PSOG_ASSERT_NEXT(a_stall_holds, (state_q == S_MUL) && out_busy, state_q == S_MUL,
		"result dropped while output stalled")

endmodule

`default_nettype wire

// ----- rtl/pixel_shift_orbit_generator_unit.sv -----
// Pixel shift orbit generator (burn-in protection), top level.
// Depends on psog_pkg, psog_tick_if, psog_shift_if, psog_regs, psog_ctrl, psog_dp.
//
// Usage:
//   tick   : one item per display frame (elapsed_us, room_x_q4, room_y_q4),
//            accepted when valid and ready are both high.
//   result : one item per tick (shift_x_q4, shift_y_q4, Q9.4 two's complement).
//   APB    : range_q4 at 0x0, speed_q4 at 0x4, flip_x at 0x8, flip_y at 0xC;
//            write only while no tick is in flight.
// Timing: a tick that moves the phases runs a one-bit-per-cycle divider,
//   then the phase update, wave and scaling steps. The result is loaded into
//   the output register, and the next tick is taken only after that load.
//   A tick with zero range or zero elapsed time skips the divider and the
//   phase update. The divider sets the rate.
// Reset: phases clear to zero, registers return to their reset values, the
//   output register is empty.
// Stall: a held result stays in the output register; the next tick is still
//   accepted and computed, then waits until the register is freed.
`default_nettype none

module pixel_shift_orbit_generator_unit import psog_pkg::*; #(
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	psog_tick_if.sink                  tick,
	psog_shift_if.source               result
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	psog_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psog_ctrl #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	psog_dp #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.tick   (tick),
		.result (result)
	);

endmodule

`default_nettype wire
